// File: sv/bba_pkg.sv
// shared types and constants of the block allocator
package bba_pkg;

  // default parameters
  localparam int NUM_BLOCKS_DEF = 65536;
  localparam int WORD_BITS_DEF  = 32;

  // field widths
  localparam int MODE_W     = 3;
  localparam int BLK_W      = 16;
  localparam int CNT_W      = 17;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 17;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FORMAT  = 3'd4;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESERVED = 1'b1;

  // count limits and register reset values
  localparam logic [CNT_W-1:0] FREE_MAX  = 17'd65536;
  localparam logic [CNT_W-1:0] TOTAL_RST = 17'd65536;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RMW,
    ST_SCAN,
    ST_FORMAT,
    ST_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic fail;
    logic grant;
    logic rmw;
    logic blk_rd;
    logic scan_start;
    logic scan_next;
    logic fmt_start;
    logic sweep;
    logic sweep_zero;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              alloc_none;
    logic              word_full;
    logic              found_ok;
    logic              scan_end;
    logic              sweep_last;
    logic              out_free;
  } status_t;

endpackage

// File: sv/bba_ram.sv
// generic single-write, single-read memory with registered read data
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/bba_ctrl.sv
// controller state machine of the block allocator
module bba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  bba_pkg::status_t status,
  output bba_pkg::cmd_t    cmd
);

  bba_pkg::state_t state_r;
  bba_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::ST_CLEAR: begin
        if (status.sweep_last) state_nxt = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = bba_pkg::ST_DISPATCH;
      end
      bba_pkg::ST_DISPATCH: begin
        case (status.mode)
          bba_pkg::MODE_ALLOC: begin
            state_nxt = status.alloc_none ? bba_pkg::ST_RESP : bba_pkg::ST_SCAN;
          end
          bba_pkg::MODE_RELEASE, bba_pkg::MODE_WRITE, bba_pkg::MODE_READ: begin
            state_nxt = bba_pkg::ST_RMW;
          end
          bba_pkg::MODE_FORMAT: state_nxt = bba_pkg::ST_FORMAT;
          default:              state_nxt = bba_pkg::ST_RESP;
        endcase
      end
      bba_pkg::ST_RMW: state_nxt = bba_pkg::ST_RESP;
      bba_pkg::ST_SCAN: begin
        if (!status.word_full || status.scan_end) state_nxt = bba_pkg::ST_RESP;
      end
      bba_pkg::ST_FORMAT: begin
        if (status.sweep_last) state_nxt = bba_pkg::ST_RESP;
      end
      bba_pkg::ST_RESP: begin
        if (status.out_free) state_nxt = bba_pkg::ST_IDLE;
      end
      default: state_nxt = bba_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      bba_pkg::ST_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = 1'b1;
      end
      bba_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      bba_pkg::ST_DISPATCH: begin
        case (status.mode)
          bba_pkg::MODE_ALLOC: begin
            cmd.fail       = status.alloc_none;
            cmd.scan_start = !status.alloc_none;
          end
          bba_pkg::MODE_RELEASE, bba_pkg::MODE_WRITE, bba_pkg::MODE_READ: begin
            cmd.blk_rd = 1'b1;
          end
          bba_pkg::MODE_FORMAT: cmd.fmt_start = 1'b1;
          default: ;
        endcase
      end
      bba_pkg::ST_RMW: cmd.rmw = 1'b1;
      bba_pkg::ST_SCAN: begin
        if (!status.word_full) begin
          cmd.grant = status.found_ok;
          cmd.fail  = !status.found_ok;
        end else if (status.scan_end) begin
          cmd.fail = 1'b1;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      bba_pkg::ST_FORMAT: cmd.sweep = 1'b1;
      bba_pkg::ST_RESP:   cmd.load_out = status.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // an accepted word always moves on to dispatch
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == bba_pkg::ST_DISPATCH))
    else $error("accepted word did not reach dispatch");

  // no word is taken while the map is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::ST_CLEAR) |-> !in_tready)
    else $error("input ready during clearing pass");

  // input is offered only while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == bba_pkg::ST_IDLE))
    else $error("input ready outside idle");
`endif

endmodule

// File: sv/bba_dp.sv
// datapath of the block allocator: bitmap memory, counters, result register
module bba_dp #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bba_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [bba_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  bba_pkg::cmd_t                     cmd,
  output bba_pkg::status_t                  status
);

  // word width rounded up to a power of two; block order is unaffected
  localparam int WB_LOG    = $clog2(WORD_BITS);
  localparam int WB        = 1 << WB_LOG;
  // only the first 65536 blocks can ever be addressed
  localparam int EFF       = (NUM_BLOCKS < 65536) ? NUM_BLOCKS : 65536;
  localparam int MAP_WORDS = (EFF + WB - 1) / WB;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = bba_pkg::CNT_W;
  localparam int BW        = bba_pkg::BLK_W;
  localparam int MW        = bba_pkg::MODE_W;
  localparam logic [CW-1:0] EFF_CNT   = CW'(EFF);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [WB-1:0] ONE_BIT   = WB'(1);

  // registers
  logic [MW-1:0] mode_r, mode_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic          bv_r, bv_nxt;
  logic [BW-1:0] res_r, res_nxt;
  logic          rd_r, rd_nxt;
  logic          st_r, st_nxt;
  logic [AW-1:0] wcnt_r, wcnt_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [BW-1:0] reserved_r, reserved_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_res_r, out_res_nxt;
  logic          out_rd_r, out_rd_nxt;
  logic          out_st_r, out_st_nxt;
  logic [CW-1:0] out_free_r, out_free_nxt;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WB-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [WB-1:0] rdata;

  // derived values
  logic [CW-1:0]     lim;
  logic [CW-1:0]     marked_raw;
  logic [CW-1:0]     marked;
  logic [CW-1:0]     base;
  logic [CW:0]       nbase;
  logic [CW-1:0]     fmt_diff;
  logic [WB-1:0]     fmt_word;
  logic [WB_LOG-1:0] zpos;
  logic [CW-1:0]     found_blk;
  logic              word_full;
  logic              found_ok;
  logic [AW-1:0]     blk_word;
  logic [WB_LOG-1:0] blk_pos;
  logic              blk_ok;
  logic              out_free;

  // limits and format boundary
  always_comb begin
    lim        = (total_r < EFF_CNT) ? total_r : EFF_CNT;
    marked_raw = {1'b0, reserved_r} + CW'(1);
    marked     = (marked_raw < lim) ? marked_raw : lim;
    base       = CW'(wcnt_r) << WB_LOG;
    nbase      = {1'b0, base} + (CW + 1)'(WB);
    fmt_diff   = marked - base;
  end

  // word pattern written by the format sweep
  always_comb begin
    if (nbase <= {1'b0, marked}) begin
      fmt_word = '1;
    end else if (base >= marked) begin
      fmt_word = '0;
    end else begin
      fmt_word = ~({WB{1'b1}} << fmt_diff[WB_LOG-1:0]);
    end
  end

  // lowest free bit of the word under scan
  always_comb begin
    zpos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!rdata[i]) zpos = WB_LOG'(i);
    end
  end

  always_comb begin
    word_full = &rdata;
    found_blk = base + CW'(zpos);
    found_ok  = found_blk < lim;
    blk_word  = AW'(blk_r >> WB_LOG);
    blk_pos   = blk_r[WB_LOG-1:0];
    blk_ok    = {1'b0, blk_r} < EFF_CNT;
    out_free  = !out_valid_r || out_tready;
  end

  // status to the controller
  always_comb begin
    status.mode       = mode_r;
    status.alloc_none = (free_r == '0) || (lim == '0);
    status.word_full  = word_full;
    status.found_ok   = found_ok;
    status.scan_end   = (nbase >= {1'b0, lim}) || (wcnt_r == LAST_WORD);
    status.sweep_last = (wcnt_r == LAST_WORD);
    status.out_free   = out_free;
  end

  // memory read port
  always_comb begin
    mem_re    = cmd.blk_rd || cmd.scan_start || cmd.scan_next;
    mem_raddr = '0;
    if (cmd.blk_rd) begin
      mem_raddr = blk_word;
    end else if (cmd.scan_next) begin
      mem_raddr = wcnt_r + AW'(1);
    end
  end

  // memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wcnt_r;
    mem_wdata = '0;
    if (cmd.sweep) begin
      mem_we    = 1'b1;
      mem_wdata = cmd.sweep_zero ? '0 : fmt_word;
    end else if (cmd.grant) begin
      mem_we    = 1'b1;
      mem_wdata = rdata | (ONE_BIT << zpos);
    end else if (cmd.rmw && blk_ok) begin
      mem_waddr = blk_word;
      case (mode_r)
        bba_pkg::MODE_RELEASE: begin
          mem_we    = 1'b1;
          mem_wdata = rdata & ~(ONE_BIT << blk_pos);
        end
        bba_pkg::MODE_WRITE: begin
          mem_we    = 1'b1;
          mem_wdata = bv_r ? (rdata | (ONE_BIT << blk_pos))
                           : (rdata & ~(ONE_BIT << blk_pos));
        end
        default: ;
      endcase
    end
  end

  // item and result registers
  always_comb begin
    mode_nxt = mode_r;
    blk_nxt  = blk_r;
    bv_nxt   = bv_r;
    res_nxt  = res_r;
    rd_nxt   = rd_r;
    st_nxt   = st_r;
    if (cmd.capture) begin
      mode_nxt = in_tdata[MW-1:0];
      blk_nxt  = in_tdata[MW+BW-1:MW];
      bv_nxt   = in_tdata[MW+BW];
      res_nxt  = in_tdata[MW+BW-1:MW];
      rd_nxt   = 1'b0;
      st_nxt   = 1'b0;
    end
    if (cmd.fail) st_nxt = 1'b1;
    if (cmd.grant) res_nxt = found_blk[BW-1:0];
    if (cmd.rmw && (mode_r == bba_pkg::MODE_READ)) begin
      rd_nxt = blk_ok ? rdata[blk_pos] : 1'b0;
    end
  end

  // word counter and free count
  always_comb begin
    wcnt_nxt = wcnt_r;
    free_nxt = free_r;
    if (cmd.sweep || cmd.scan_next) wcnt_nxt = wcnt_r + AW'(1);
    if (cmd.scan_start || cmd.fmt_start) wcnt_nxt = '0;
    if (cmd.fmt_start) free_nxt = lim - marked;
    if (cmd.grant) free_nxt = free_r - CW'(1);
    if (cmd.rmw && (mode_r == bba_pkg::MODE_RELEASE) && (free_r < bba_pkg::FREE_MAX)) begin
      free_nxt = free_r + CW'(1);
    end
  end

  // configuration registers
  always_comb begin
    total_nxt    = total_r;
    reserved_nxt = reserved_r;
    if (cfg_we) begin
      case (cfg_addr)
        bba_pkg::CFG_TOTAL:    total_nxt    = cfg_data;
        bba_pkg::CFG_RESERVED: reserved_nxt = cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_rd_nxt    = out_rd_r;
    out_st_nxt    = out_st_r;
    out_free_nxt  = out_free_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
      out_rd_nxt    = rd_r;
      out_st_nxt    = st_r;
      out_free_nxt  = free_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    blk_r      <= blk_nxt;
    bv_r       <= bv_nxt;
    res_r      <= res_nxt;
    rd_r       <= rd_nxt;
    st_r       <= st_nxt;
    out_res_r  <= out_res_nxt;
    out_rd_r   <= out_rd_nxt;
    out_st_r   <= out_st_nxt;
    out_free_r <= out_free_nxt;
  end

  // control and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r      <= '0;
      free_r      <= EFF_CNT;
      total_r     <= bba_pkg::TOTAL_RST;
      reserved_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wcnt_r      <= wcnt_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      reserved_r  <= reserved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // bitmap storage
  bba_ram #(
    .WIDTH (WB),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bba_pkg::OUT_DATA_W - BW - 2 - CW){1'b0}},
                       out_free_r, out_st_r, out_rd_r, out_res_r};

`ifndef SYNTHESIS
  // free count never exceeds its ceiling
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= bba_pkg::FREE_MAX)
    else $error("free count above ceiling");

  // a grant takes exactly one block from the count
  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> (free_r == $past(free_r) - CW'(1)))
    else $error("grant did not decrement free count");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten while stalled");
`endif

endmodule

// File: sv/bitmap_block_allocator.sv
// top level of the first-fit block allocator
//
// One word in on the in_ channel carries an operation: allocate, release,
// write bit, read bit or format. Each accepted word gives exactly one result
// word on the out_ channel, in order. Registers total_blocks (index 0) and
// reserved_blocks (index 1) are written through cfg_we/cfg_addr/cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// An accepted word goes through dispatch to the result: directly for an
// allocate that finds no free count and for unused modes, through one
// read-modify-write of a bitmap word for release, write and read, through a
// scan of bitmap words (one word per cycle through the memory read port) for
// an allocate, and through a sweep that rewrites every bitmap word once for format.
// Items are handled one at a time; a new word can be taken in the cycle after the
// result is loaded into the output register.
// After reset the bitmap is swept to all free, one word per cycle, across all
// MAP_WORDS words (2048 with the defaults); in_tready stays low meanwhile.
// A stalled receiver holds the result in the output register; the block
// still accepts one more word and works on it, then waits to deliver.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // mode[2:0], block_number[18:3], bit_value[19]
  input  logic [bba_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // result_block[15:0], read_value[16], status[17], free_count[34:18]
  output logic [bba_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [bba_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);

  bba_pkg::cmd_t    cmd;
  bba_pkg::status_t status;

  // sequencing
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage and arithmetic
  bba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
